/* rtl/apd_pkg.sv */
// ----------------------------------------------------------------------------
// apd_pkg
// shared types and constants of the audio packet deframer
// ----------------------------------------------------------------------------
package apd_pkg;

  // header layout
  localparam int HEADER_BYTES = 36;
  localparam int ADDR_W       = $clog2(HEADER_BYTES);
  localparam int CNT_W        = $clog2(HEADER_BYTES + 1);
  localparam int MAGIC_BYTES  = 4;
  localparam int VER_POS      = 4;
  localparam int LEN_POS      = HEADER_BYTES - 4;

  // field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 19;
  localparam int VER_W  = 16;
  localparam int HLEN_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEN_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd1;

  // register reset values
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 19'd262144;
  localparam logic [VER_W-1:0] VERSION_RST     = 16'd1;

  // frame magic, byte 0 first
  localparam logic [BYTE_W-1:0] MAGIC [MAGIC_BYTES] = '{8'h58, 8'h52, 8'h41, 8'h55};

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2,
    PH_BURST   = 2'd3
  } phase_t;

  // header check status handed to the control
  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] len;
  } chk_t;

endpackage

/* rtl/audio_packet_deframer.sv */
// ----------------------------------------------------------------------------
// audio_packet_deframer
// length-prefixed packet deframer with header check and header replay
// ----------------------------------------------------------------------------
// Bytes come in one per transfer. The first 36 bytes of a packet are kept in
// a small header memory while the magic, the big-endian version at byte 4 and
// the big-endian payload length at byte 32 are captured on the fly. A header
// byte is taken and gives no output, except the last one: if the
// header is good, the input is held off and the header is replayed from the
// memory, the first byte marked start. The input stays held off while the
// header memory is first read and then replayed at one byte per cycle when
// the output does not stall, set by the single read port of the header
// memory. After that each payload byte passes through the output register,
// the last one marked end. If the header is bad, a
// single error transfer goes out and all later bytes are swallowed until a
// byte arrives with the new-connection flag, which clears the state before
// that byte is taken as the first header byte. Every output transfer has
// tlast set when it is the last one caused by its input byte. One output
// register decouples the sides; a stalled output stalls the input. The
// configuration registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module audio_packet_deframer (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [apd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apd_pkg::CFG_DATA_W-1:0] cfg_data,
  // input byte stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] in_byte
  input  logic                           s_axis_tuser,  // [0] new_connection
  // output packet stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]                     m_axis_tuser,  // [0] packet_start,
                                                        // [1] packet_end,
                                                        // [2] stream_error
  output logic                           m_axis_tlast   // run_last
);

  localparam int ADDR_W = apd_pkg::ADDR_W;
  localparam int CNT_W  = apd_pkg::CNT_W;
  localparam int LEN_W  = apd_pkg::LEN_W;

  // configuration registers
  logic [LEN_W-1:0]          max_payload;
  logic [apd_pkg::VER_W-1:0] expected_version;

  // control state
  apd_pkg::phase_t  phase, phase_next;
  logic [ADDR_W-1:0] header_count;
  logic [LEN_W-1:0]  payload_left;
  logic [CNT_W-1:0]  rd_addr;       // next header entry to replay
  logic              rd_pend;       // read data waiting for the output register

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic [2:0] out_user;
  logic       out_last;

  // handshakes and decoded controls
  logic              in_fire;
  logic              out_free;
  apd_pkg::phase_t   eff_phase;
  logic [ADDR_W-1:0] eff_count;
  logic              hdr_last;
  logic              pay_end;
  logic              wr_en;
  logic              rd_issue;
  logic              burst_load;
  logic              burst_done;
  logic [7:0]        rd_data;
  apd_pkg::chk_t     chk;

  // --------------------------------------------------------------------------
  // configuration: always ready, unknown indexes are ignored
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload      <= apd_pkg::MAX_PAYLOAD_RST;
      expected_version <= apd_pkg::VERSION_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == apd_pkg::CFG_MAX_PAYLOAD) begin
        max_payload <= cfg_data;
      end else if (cfg_index == apd_pkg::CFG_VERSION) begin
        expected_version <= cfg_data[apd_pkg::VER_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // input decode: a new connection restarts header collection for this byte
  // --------------------------------------------------------------------------
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid || m_axis_tready;
  assign eff_phase = s_axis_tuser ? apd_pkg::PH_HEADER : phase;
  assign eff_count = s_axis_tuser ? '0 : header_count;
  assign hdr_last  = (eff_count == ADDR_W'(apd_pkg::HEADER_BYTES - 1));
  assign pay_end   = (payload_left <= LEN_W'(1));

  // header replay: data for entry rd_addr-1 sits in rd_data while pending
  assign burst_load = (phase == apd_pkg::PH_BURST) && rd_pend && out_free;
  assign burst_done = burst_load && (rd_addr == CNT_W'(apd_pkg::HEADER_BYTES));

  // --------------------------------------------------------------------------
  // phase sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      unique case (eff_phase)
        apd_pkg::PH_HEADER: begin
          if (hdr_last) begin
            phase_next = chk.ok ? apd_pkg::PH_BURST : apd_pkg::PH_DROP;
          end else begin
            phase_next = apd_pkg::PH_HEADER;
          end
        end
        apd_pkg::PH_PAYLOAD: begin
          if (pay_end) begin
            phase_next = apd_pkg::PH_HEADER;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end else if (burst_done) begin
      phase_next = apd_pkg::PH_PAYLOAD;
    end
  end

  // --------------------------------------------------------------------------
  // phase sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    rd_issue      = 1'b0;
    unique case (phase)
      apd_pkg::PH_BURST: begin
        rd_issue = (rd_addr != CNT_W'(apd_pkg::HEADER_BYTES)) && (!rd_pend || burst_load);
      end
      default: begin
        s_axis_tready = out_free;
      end
    endcase
  end

  assign wr_en = in_fire && (eff_phase == apd_pkg::PH_HEADER);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= apd_pkg::PH_HEADER;
    end else begin
      phase <= phase_next;
    end
  end

  // header byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
    end else if (wr_en) begin
      header_count <= hdr_last ? '0 : eff_count + ADDR_W'(1);
    end else if (in_fire && s_axis_tuser) begin
      header_count <= '0;
    end
  end

  // payload countdown, loaded from the checked length
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_left <= '0;
    end else if (wr_en && hdr_last && chk.ok) begin
      payload_left <= chk.len;
    end else if (in_fire && eff_phase == apd_pkg::PH_PAYLOAD) begin
      payload_left <= pay_end ? '0 : payload_left - LEN_W'(1);
    end else if (in_fire && s_axis_tuser) begin
      payload_left <= '0;
    end
  end

  // replay read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      rd_pend <= 1'b0;
    end else if (phase != apd_pkg::PH_BURST) begin
      rd_addr <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (rd_issue) begin
        rd_addr <= rd_addr + CNT_W'(1);
        rd_pend <= 1'b1;
      end else if (burst_load) begin
        rd_pend <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (burst_load) begin
      out_valid <= 1'b1;
    end else if (in_fire && eff_phase == apd_pkg::PH_PAYLOAD) begin
      out_valid <= 1'b1;
    end else if (wr_en && hdr_last && !chk.ok) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // payload fields: {stream_error, packet_end, packet_start}
  always_ff @(posedge clk) begin
    if (burst_load) begin
      out_byte <= rd_data;
      out_user <= {2'b00, rd_addr == CNT_W'(1)};
      out_last <= (rd_addr == CNT_W'(apd_pkg::HEADER_BYTES));
    end else if (in_fire && eff_phase == apd_pkg::PH_PAYLOAD) begin
      out_byte <= s_axis_tdata;
      out_user <= {1'b0, pay_end, 1'b0};
      out_last <= 1'b1;
    end else if (wr_en && hdr_last && !chk.ok) begin
      out_byte <= '0;
      out_user <= 3'b100;
      out_last <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = out_user;
  assign m_axis_tlast  = out_last;

  // --------------------------------------------------------------------------
  // header store and field check
  // --------------------------------------------------------------------------
  apd_hdr_mem u_hdr_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (eff_count),
    .wr_data (s_axis_tdata),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  apd_hdr_check u_hdr_check (
    .clk              (clk),
    .wr_en            (wr_en),
    .wr_addr          (eff_count),
    .wr_data          (s_axis_tdata),
    .max_payload      (max_payload),
    .expected_version (expected_version),
    .chk              (chk)
  );

endmodule

/* rtl/apd_hdr_mem.sv */
// ----------------------------------------------------------------------------
// apd_hdr_mem
// header byte store, one write port, one registered read port
// ----------------------------------------------------------------------------
module apd_hdr_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [apd_pkg::ADDR_W-1:0] wr_addr,
  input  logic [apd_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [apd_pkg::ADDR_W-1:0] rd_addr,
  output logic [apd_pkg::BYTE_W-1:0] rd_data
);

  logic [apd_pkg::BYTE_W-1:0] mem [apd_pkg::HEADER_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/apd_hdr_check.sv */
// ----------------------------------------------------------------------------
// apd_hdr_check
// header field capture while bytes arrive, verdict on the last header byte
// ----------------------------------------------------------------------------
module apd_hdr_check (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [apd_pkg::ADDR_W-1:0] wr_addr,
  input  logic [apd_pkg::BYTE_W-1:0] wr_data,
  input  logic [apd_pkg::LEN_W-1:0]  max_payload,
  input  logic [apd_pkg::VER_W-1:0]  expected_version,
  output apd_pkg::chk_t              chk
);

  logic [apd_pkg::MAGIC_BYTES-1:0] magic_hit;
  logic [apd_pkg::VER_W-1:0]       version;
  logic [apd_pkg::HLEN_W-9:0]      len_hi;   // length bytes before the last one
  logic [apd_pkg::HLEN_W-1:0]      len_full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < apd_pkg::MAGIC_BYTES; i++) begin
        if (wr_addr == apd_pkg::ADDR_W'(i)) begin
          magic_hit[i] <= (wr_data == apd_pkg::MAGIC[i]);
        end
      end
      if (wr_addr == apd_pkg::ADDR_W'(apd_pkg::VER_POS)) begin
        version[15:8] <= wr_data;
      end
      if (wr_addr == apd_pkg::ADDR_W'(apd_pkg::VER_POS + 1)) begin
        version[7:0] <= wr_data;
      end
      for (int i = 0; i < 3; i++) begin
        if (wr_addr == apd_pkg::ADDR_W'(apd_pkg::LEN_POS + i)) begin
          len_hi[(2-i)*8 +: 8] <= wr_data;
        end
      end
    end
  end

  // verdict is valid in the cycle the last length byte is written
  assign len_full = {len_hi, wr_data};
  assign chk.ok   = (&magic_hit) && (version == expected_version) &&
                    (len_full != '0) &&
                    (len_full <= {{(apd_pkg::HLEN_W - apd_pkg::LEN_W){1'b0}}, max_payload});
  assign chk.len  = len_full[apd_pkg::LEN_W-1:0];

endmodule

/* dv/tb_audio_packet_deframer.sv */
// ----------------------------------------------------------------------------
// tb_audio_packet_deframer
// self-checking stream testbench for the length-prefixed packet deframer
// ----------------------------------------------------------------------------
// A queue of pending stream bytes feeds a bursty driver, and a monitor takes
// the relayed packet stream behind a receiver that stalls in changing
// patterns. Every accepted byte runs through a local deframer model that
// keeps its own header memory, phase and registers and queues the transfers
// the block has to produce, which the monitor checks field by field. A
// directed part hits the header checks and their limits and new connections
// in the payload, drop and header phases, then a short stretch of random
// traffic runs under random settings.
// ----------------------------------------------------------------------------
module tb_audio_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  // four sync bytes that open every header, byte 0 in the top bits
  localparam logic [31:0] SYNC_WORD     = 32'h5852_4155;
  // register indexes the block has to ignore
  localparam logic [apd_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [apd_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  // idle time before a register write and at the end: covers the header burst
  localparam int          SETTLE_CYCLES = 60;
  // cycles without any transfer before the run is declared hung
  localparam int          QUIET_LIMIT   = 3000;
  localparam int          MAX_REPORTS   = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       nc;      // new connection
  } stream_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       stop;
    logic       err;
    logic       last;
  } relay_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [apd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [apd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;   // [7:0] in_byte
  logic                           s_axis_tuser = 1'b0; // [0] new_connection
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;        // [7:0] out_byte
  logic [2:0]                     m_axis_tuser;        // [0] start, [1] end, [2] error
  logic                           m_axis_tlast;        // last transfer of its input byte

  audio_packet_deframer i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // pending stimulus and expected output transfers
  stream_item_t stream_q [$];
  relay_t       relay_q [$];
  stream_item_t nxt;

  // local deframer state and registers
  logic [7:0]      hdr_mem [apd_pkg::HEADER_BYTES];
  int              hdr_cnt;
  logic [18:0]     bytes_to_go;
  apd_pkg::phase_t ph;
  logic [18:0]     max_len_cfg;
  logic [15:0]     version_cfg;

  // driver and receiver pacing
  int burst_left, gap_left;
  int stall_mode, stall_hold, stall_tick;
  int quiet;

  // statistics
  int n_fail, n_in, n_out, n_start, n_err, n_writes, n_gen;

  task automatic clear_frame_state();
    for (int k = 0; k < apd_pkg::HEADER_BYTES; k++) hdr_mem[k] = 8'h00;
    hdr_cnt     = 0;
    bytes_to_go = '0;
    ph          = apd_pkg::PH_HEADER;
  endtask

  // advance the model by one accepted byte, queue what the block must send
  task automatic deframe_byte(input logic [7:0] b, input logic nc);
    logic [31:0] len;
    logic [15:0] ver;
    logic [31:0] sync;
    relay_t      r;
    if (nc) clear_frame_state();
    case (ph)
      apd_pkg::PH_PAYLOAD: begin
        r.data  = b;
        r.start = 1'b0;
        r.stop  = (bytes_to_go <= 19'd1);
        r.err   = 1'b0;
        r.last  = 1'b1;
        relay_q.push_back(r);
        if (bytes_to_go <= 19'd1) begin
          bytes_to_go = '0;
          ph          = apd_pkg::PH_HEADER;
        end else begin
          bytes_to_go = bytes_to_go - 19'd1;
        end
      end
      apd_pkg::PH_HEADER: begin
        if (hdr_cnt >= apd_pkg::HEADER_BYTES) hdr_cnt = 0;
        hdr_mem[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt == apd_pkg::HEADER_BYTES) begin
          hdr_cnt = 0;
          sync = {hdr_mem[0], hdr_mem[1], hdr_mem[2], hdr_mem[3]};
          ver  = {hdr_mem[4], hdr_mem[5]};
          len  = {hdr_mem[32], hdr_mem[33], hdr_mem[34], hdr_mem[35]};
          if (sync != SYNC_WORD || ver != version_cfg || len == 32'd0 ||
              len > {13'd0, max_len_cfg}) begin
            // bad header: one error transfer, then swallow everything
            r.data  = 8'h00;
            r.start = 1'b0;
            r.stop  = 1'b0;
            r.err   = 1'b1;
            r.last  = 1'b1;
            relay_q.push_back(r);
            ph = apd_pkg::PH_DROP;
          end else begin
            // good header: replay it, first byte marked start
            for (int k = 0; k < apd_pkg::HEADER_BYTES; k++) begin
              r.data  = hdr_mem[k];
              r.start = (k == 0);
              r.stop  = 1'b0;
              r.err   = 1'b0;
              r.last  = (k == apd_pkg::HEADER_BYTES - 1);
              relay_q.push_back(r);
            end
            bytes_to_go = len[18:0];
            ph          = apd_pkg::PH_PAYLOAD;
          end
        end
      end
      default: ; // dropping until a new connection
    endcase
  endtask

  // driver: bursts of transfers with random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      clear_frame_state();
      max_len_cfg = apd_pkg::MAX_PAYLOAD_RST;
      version_cfg = apd_pkg::VERSION_RST;
      burst_left  = 0;
      gap_left    = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        deframe_byte(s_axis_tdata, s_axis_tuser);
        n_in++;
      end
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (stream_q.size() > 0) begin
        nxt = stream_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tuser  <= nxt.nc;
        burst_left--;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: free flow, random stalls, one-in-four, mostly ready
  always @(posedge clk) begin
    stall_tick++;
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(64, 256);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (stall_tick % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // monitor: every output transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_out++;
      if (m_axis_tuser[0]) n_start++;
      if (m_axis_tuser[2]) n_err++;
      if (relay_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("%0t: unexpected transfer, expected none, got data %0h user %b last %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        check_field("out_byte",     relay_q[0].data,      m_axis_tdata);
        check_field("packet_start", 8'(relay_q[0].start), 8'(m_axis_tuser[0]));
        check_field("packet_end",   8'(relay_q[0].stop),  8'(m_axis_tuser[1]));
        check_field("stream_error", 8'(relay_q[0].err),   8'(m_axis_tuser[2]));
        check_field("tlast",        8'(relay_q[0].last),  8'(m_axis_tlast));
        void'(relay_q.pop_front());
      end
    end
  end

  // watchdog: no transfer on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d transfers still expected",
               $time, QUIET_LIMIT, relay_q.size());
      $display("audio_packet_deframer verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_item(input logic [7:0] b, input logic nc);
    stream_item_t it;
    it.data = b;
    it.nc   = nc;
    stream_q.push_back(it);
    n_gen++;
  endtask

  task automatic push_payload(input int n);
    for (int k = 0; k < n; k++) push_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // full header; new connection flag only on its first byte
  task automatic push_header(input logic [31:0] sync, input logic [15:0] ver,
                             input logic [31:0] len, input logic nc);
    logic [7:0] b;
    for (int k = 0; k < apd_pkg::HEADER_BYTES; k++) begin
      if (k < 4)        b = sync[31 - 8*k -: 8];
      else if (k == 4)  b = ver[15:8];
      else if (k == 5)  b = ver[7:0];
      else if (k >= 32) b = len[31 - 8*(k-32) -: 8];
      else              b = 8'($urandom_range(0, 255));
      push_item(b, nc && (k == 0));
    end
  endtask

  // wait until the block has nothing left to do; sampled after the edge settles
  task automatic drain();
    do @(negedge clk);
    while (stream_q.size() != 0 || s_axis_tvalid || relay_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [apd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      apd_pkg::CFG_MAX_PAYLOAD: max_len_cfg = val;
      apd_pkg::CFG_VERSION:     version_cfg = val[15:0];
      default: ; // spare index, no effect
    endcase
    n_writes++;
    cfg_valid <= 1'b0;
  endtask

  // random traffic: mostly good packets, some broken headers and noise
  task automatic random_traffic(input int n_items);
    int          base, pick, plen, cap;
    logic        need_nc;
    logic [31:0] len;
    base    = n_gen;
    need_nc = 1'b1;
    while (n_gen - base < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70 && max_len_cfg != 0) begin
        cap  = (max_len_cfg < 12) ? int'(max_len_cfg) : 12;
        plen = $urandom_range(1, cap);
        push_header(SYNC_WORD, version_cfg, plen, need_nc);
        if ($urandom_range(0, 5) == 0) begin
          // payload cut short, the next packet opens a new connection
          push_payload($urandom_range(0, plen - 1));
          need_nc = 1'b1;
        end else begin
          push_payload(plen);
          need_nc = ($urandom_range(0, 2) == 0);
        end
      end else if (pick < 88) begin
        case ($urandom_range(0, 2))
          0: push_header(SYNC_WORD ^ (32'd1 << $urandom_range(0, 31)), version_cfg,
                         32'd1, need_nc);
          1: push_header(SYNC_WORD, version_cfg ^ 16'($urandom_range(1, 65535)),
                         32'd1, need_nc);
          default: begin
            if ($urandom_range(0, 2) == 0) len = 32'd0;
            else if ($urandom_range(0, 1) == 0) len = $urandom | 32'h8000_0000;
            else len = {13'd0, max_len_cfg} + 32'd1 + $urandom_range(0, 1000);
            push_header(SYNC_WORD, version_cfg, len, need_nc);
          end
        endcase
        push_payload($urandom_range(0, 4));  // swallowed
        need_nc = 1'b1;
      end else begin
        // stray bytes that misalign header collection
        push_payload($urandom_range(1, 6));
        need_nc = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // register reset values: limit 262144, version 1
    // length exactly at the limit, payload at the byte extremes, then cut
    // short by a new connection in the middle of the payload
    push_header(SYNC_WORD, 16'd1, 32'd262144, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'hff, 1'b0);
    // wrong sync byte: error, then dropping
    push_header(SYNC_WORD ^ 32'h0000_0100, 16'd1, 32'd1, 1'b1);
    // new connection while dropping, then again in the middle of a header
    push_item(8'h58, 1'b1);
    push_payload(3);
    // shortest packet with an all-ones payload byte
    push_header(SYNC_WORD, 16'd1, 32'd1, 1'b1);
    push_item(8'hff, 1'b0);
    drain();

    // small limit; version zero written with upper data bits set
    write_reg(apd_pkg::CFG_MAX_PAYLOAD, 19'd5);
    write_reg(apd_pkg::CFG_VERSION, 19'h70000);
    // spare indexes must leave the registers alone
    write_reg(CFG_SPARE_2, 19'd0);
    write_reg(CFG_SPARE_3, 19'h7ffff);
    // one over the limit, zero length, version mismatch, then right at the limit
    push_header(SYNC_WORD, 16'd0, 32'd6, 1'b1);
    push_header(SYNC_WORD, 16'd0, 32'd0, 1'b1);
    push_header(SYNC_WORD, 16'd1, 32'd5, 1'b1);
    push_header(SYNC_WORD, 16'd0, 32'd5, 1'b1);
    push_payload(5);
    drain();

    // random settings with a short stretch of random traffic
    write_reg(apd_pkg::CFG_MAX_PAYLOAD, 19'($urandom_range(1, 40)));
    write_reg(apd_pkg::CFG_VERSION, 19'($urandom_range(0, 65535)));
    random_traffic(1);
    drain();

    $display("ran %0d input and %0d output transfers over %0d register writes",
             n_in, n_out, n_writes);
    $display("%0d packets relayed, %0d headers rejected", n_start, n_err);
    if (n_fail == 0 && relay_q.size() == 0) begin
      $display("audio_packet_deframer verification clean");
    end else begin
      $display("audio_packet_deframer verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/apd_pkg.sv
rtl/apd_hdr_mem.sv
rtl/apd_hdr_check.sv
rtl/audio_packet_deframer.sv
dv/tb_audio_packet_deframer.sv
